@@ src/sha_pkg.sv @@
// Package with SHA-256 constants, payload types and round functions.
package sha_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        is_last;
  } out_item_t;

  localparam logic ActAbsorb = 1'b0;
  localparam logic ActFinish = 1'b1;
  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned LenPos = 56;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

endpackage

@@ src/sha_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ src/sha_round.sv @@
// One SHA-256 round with a 16-word rolling message schedule.
module sha_round import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [31:0] h_i [8],
  input  logic        step_i,
  input  logic [5:0]  round_i,
  input  logic [31:0] w_new_i,
  output logic [31:0] v_o [8]
);

  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] w_cur, t1, t2;

  always_comb begin
    if (round_i < 6'd16) begin
      w_cur = w_new_i;
    end else begin
      w_cur = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
    end
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + RoundK[round_i] + w_cur;
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // The schedule window holds w[i-16] .. w[i-1] with the oldest at index 0.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      v_q <= h_i;
    end else if (step_i) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_cur;
    end
  end

  assign v_o = v_q;

endmodule

@@ src/sha256_byte_hasher_core.sv @@
// SHA-256 byte hasher top level: block buffer memory, sequencer and digest output.
// Each absorbed byte is written to a 64-byte block buffer RAM. The byte that
// fills a block starts a compression, during which input is stalled: a load
// state, 64 byte reads that feed rounds 0..15 as each word completes, 48 more
// rounds at one per cycle after the last schedule word, and a fold state. A
// finish writes the padding one byte per cycle (64 minus the pending byte
// count, or all 64 for a second padded block), runs one or two compressions
// and then offers the four 64-bit digest words, most significant first, the
// last one marked by is_last. The next message starts from the standard
// initial hash values.
module sha256_byte_hasher_core import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    StIdle, StPad, StLoad, StRun, StFold, StEmit
  } state_e;

  state_e      state_q;
  logic [5:0]  fill_q;
  logic [60:0] total_q;
  logic [31:0] h_q [8];
  logic        final_q;   // this compression ends the message
  logic        two_q;     // a second padded block follows
  logic [5:0]  pidx_q;    // pad write index
  logic [6:0]  rcnt_q;    // round counter
  logic [1:0]  bsel_q;    // byte within word while loading
  logic [31:0] wacc_q;
  logic        wval_q;
  logic [1:0]  oidx_q;
  logic [5:0]  raddr_q;
  logic        rd_pend_q;

  logic        ram_we;
  logic [5:0]  ram_addr;
  logic [7:0]  ram_wdata, ram_rdata;
  logic [31:0] v [8];
  logic        rnd_load, rnd_step;
  logic [63:0] bits;
  logic        in_acc;

  assign bits = {total_q, 3'b000};
  assign in_stall_o = (state_q != StIdle);
  assign in_acc = in_valid_i && !in_stall_o;

  sha_ram #(.Width(8), .Depth(64)) u_buf (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  sha_round u_round (
    .clk_i(clk_i), .load_i(rnd_load), .h_i(h_q), .step_i(rnd_step),
    .round_i(rcnt_q[5:0]), .w_new_i(wacc_q), .v_o(v)
  );

  // Buffer port: absorb writes in idle, padding writes in pad, reads in load and run.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = raddr_q;
    ram_wdata = in_data_i.data_byte;
    if (state_q == StIdle) begin
      ram_we = in_acc && (in_data_i.action == ActAbsorb);
      ram_addr = fill_q;
    end else if (state_q == StPad) begin
      ram_we = 1'b1;
      ram_addr = pidx_q;
      // The second padded block carries no 0x80 marker.
      if (!final_q && pidx_q == fill_q) begin
        ram_wdata = PadByte;
      end else if (!two_q && pidx_q >= 6'(LenPos)) begin
        ram_wdata = bits[8*(63 - pidx_q) +: 8];
      end else begin
        ram_wdata = 8'h00;
      end
    end else if (state_q == StLoad) begin
      ram_addr = 6'd0;
    end
  end

  assign rnd_load = (state_q == StLoad);
  // Rounds 0..15 step when a full word is assembled; later rounds every cycle.
  assign rnd_step = (state_q == StRun) && (rcnt_q < 7'd16 ? wval_q : 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q <= '0;
      total_q <= '0;
      h_q <= InitH;
      final_q <= 1'b0;
      two_q <= 1'b0;
      pidx_q <= '0;
      rcnt_q <= '0;
      bsel_q <= '0;
      wval_q <= 1'b0;
      oidx_q <= '0;
      raddr_q <= '0;
      rd_pend_q <= 1'b0;
      wacc_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (in_data_i.action == ActAbsorb) begin
              fill_q <= fill_q + 6'd1;
              total_q <= total_q + 61'd1;
              if (fill_q == 6'd63) begin
                final_q <= 1'b0;
                state_q <= StLoad;
              end
            end else begin
              two_q <= (fill_q >= 6'(LenPos));
              pidx_q <= fill_q;
              state_q <= StPad;
            end
          end
        end
        StPad: begin
          pidx_q <= pidx_q + 6'd1;
          if (pidx_q == 6'd63) begin
            final_q <= !two_q;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          raddr_q <= 6'd1;
          rd_pend_q <= 1'b1;
          rcnt_q <= '0;
          bsel_q <= '0;
          wval_q <= 1'b0;
          state_q <= StRun;
        end
        StRun: begin
          // Byte read from the address issued last cycle arrives now.
          if (rd_pend_q) begin
            wacc_q <= {wacc_q[23:0], ram_rdata};
            bsel_q <= bsel_q + 2'd1;
            wval_q <= (bsel_q == 2'd3);
            raddr_q <= raddr_q + 6'd1;
            if (bsel_q == 2'd3 && rcnt_q == 7'd15) begin
              rd_pend_q <= 1'b0;
            end
          end else begin
            wval_q <= 1'b0;
          end
          if (rnd_step) begin
            rcnt_q <= rcnt_q + 7'd1;
            if (rcnt_q == 7'd63) begin
              state_q <= StFold;
            end
          end
        end
        StFold: begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v[i];
          end
          fill_q <= '0;
          if (two_q) begin
            two_q <= 1'b0;
            final_q <= 1'b1;
            pidx_q <= '0;
            state_q <= StPad;
          end else if (final_q) begin
            oidx_q <= '0;
            state_q <= StEmit;
          end else begin
            state_q <= StIdle;
          end
        end
        StEmit: begin
          if (!out_stall_i) begin
            oidx_q <= oidx_q + 2'd1;
            if (oidx_q == 2'd3) begin
              h_q <= InitH;
              total_q <= '0;
              fill_q <= '0;
              final_q <= 1'b0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // In load, address 0 is presented so its byte arrives in the first run cycle.
  assign out_valid_o = (state_q == StEmit);
  assign out_data_o.digest_word = {h_q[{oidx_q, 1'b0}], h_q[{oidx_q, 1'b1}]};
  assign out_data_o.word_index = oidx_q;
  assign out_data_o.is_last = (oidx_q == 2'd3);

  ap_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  ap_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.is_last) |=>
    (out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 2'd1))
    else $error("digest words out of order");
  ap_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (rcnt_q < 7'd64)) else $error("round counter overrun");
  ap_fill_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.is_last) |=>
    (fill_q == 6'd0 && total_q == '0)) else $error("state not cleared after digest");

endmodule

@@ dv/sha256_byte_hasher_checker.sv @@
// Checker for the SHA-256 byte hasher: digest prediction and result comparison.
`timescale 1ns / 100ps
module sha256_byte_hasher_checker import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned fill_level;
  logic [60:0] msg_bytes;
  out_item_t   digest_queue [$];
  int          mismatch_count;

  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic fold_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = HInit[i];
    fill_level = 0;
    msg_bytes = '0;
  endtask

  task automatic absorb_or_finish(in_item_t item);
    logic [63:0] bit_len;
    out_item_t word;
    int unsigned n;
    if (item.action == ActAbsorb) begin
      msg_block[fill_level] = item.data_byte;
      fill_level++;
      msg_bytes++;
      if (fill_level == 64) begin
        fold_block();
        fill_level = 0;
      end
    end else begin
      bit_len = {msg_bytes, 3'b000};
      n = fill_level;
      msg_block[n] = PadByte;
      n++;
      if (n > LenPos) begin
        for (int i = n; i < 64; i++) msg_block[i] = 8'h00;
        fold_block();
        n = 0;
      end
      for (int i = n; i < LenPos; i++) msg_block[i] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
      fold_block();
      for (int k = 0; k < 4; k++) begin
        word.digest_word = {hash_state[2*k], hash_state[2*k+1]};
        word.word_index = k[1:0];
        word.is_last = (k == 3);
        digest_queue.push_back(word);
      end
      restart_message();
    end
  endtask

  initial begin
    restart_message();
    mismatch_count = 0;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) absorb_or_finish(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected digest word %h", out_data_i);
        end else begin
          want = digest_queue.pop_front();
          if (out_data_i.digest_word !== want.digest_word ||
              out_data_i.word_index !== want.word_index ||
              out_data_i.is_last !== want.is_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       want.digest_word, want.word_index, want.is_last,
                       out_data_i.digest_word, out_data_i.word_index, out_data_i.is_last);
          end
        end
      end
    end
  end

  assign fail_count_o = mismatch_count + digest_queue.size();
  assign pending_o = digest_queue.size();

endmodule

@@ dv/sha256_byte_hasher_core_test.sv @@
// Testbench top for the SHA-256 byte hasher: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module sha256_byte_hasher_core_test import sha_pkg::*;;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count, pending;
  int        idle_cycles = 0;
  bit        hold_off = 1'b0;

  localparam int WatchdogLimit = 20000;

  always #10 clk_i = ~clk_i;

  sha256_byte_hasher_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  sha256_byte_hasher_checker checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 3);
  endfunction

  // Sends one transaction, with an optional gap before it. Valid stays high
  // between back-to-back transactions.
  task automatic send_item(logic act, logic [7:0] value, bit allow_gap);
    int gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, data_byte: value};
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_message(int len, int kind, bit allow_gap);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_item(ActAbsorb, b, allow_gap);
    end
    send_item(ActFinish, 8'($urandom_range(0, 255)), allow_gap);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    repeat (300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, a finish with an ignored data byte, the longest
    // tail that fits one padded block, and a full block followed by a tail
    // that needs two padded blocks.
    send_item(ActFinish, 8'h00, 1'b0);
    send_item(ActFinish, 8'hff, 1'b0);
    send_message(55, 1, 1'b0);
    send_message(120, 2, 1'b1);
    // A few short random messages with random gaps.
    for (int m = 0; m < 3; m++) begin
      send_message($urandom_range(0, 6), 2, 1'b1);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
